FILE: rtl/core/mwe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_pkg: shared definitions for the Microwire EEPROM master
// Command codes, default sizes and the depth of the front-to-back queue.
// ----------------------------------------------------------------------------
package mwe_pkg;

  // Default address and data widths (x8 organization of a 1 Kbit part).
  localparam int ADDR_BITS_DEF = 7;
  localparam int DATA_BITS_DEF = 8;

  // Depth of the queue that separates the decoder from the sequencer.
  localparam int QUEUE_DEPTH = 2;

  // Width of the kind field.
  localparam int KIND_W = 3;

  // Command codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_EWEN  = 3'd3,
    CMD_EWDS  = 3'd4,
    CMD_ERAL  = 3'd5,
    CMD_WRAL  = 3'd6,
    CMD_NONE  = 3'd7
  } cmd_t;

  // Two-bit opcodes sent after the start bit.
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_EXT   = 2'b00;

  // Leading address bits that select the extended commands.
  localparam logic [1:0] EXT_EWEN = 2'b11;
  localparam logic [1:0] EXT_EWDS = 2'b00;
  localparam logic [1:0] EXT_ERAL = 2'b10;
  localparam logic [1:0] EXT_WRAL = 2'b01;

endpackage
`default_nettype wire

FILE: rtl/core/microwire_eeprom_master.sv
`default_nettype none
// ----------------------------------------------------------------------------
// microwire_eeprom_master: Microwire master for a 93C46-style EEPROM (x8)
//
// Each input item on the s_ channel is one bus tick (half a serial clock
// period) and may carry a command in s_tuser: read, write, write enable,
// write disable, erase all or write all. A command is taken only while no
// sequence runs; otherwise it is ignored and flagged as rejected. Each input
// item yields exactly one result item on the m_ channel with the pin levels
// after that tick, the last read byte, a read-done pulse, busy and rejected.
//
// A decoder builds the header and pushes a two-entry queue; the sequencer
// pops it and registers the result, so a result item passes through the
// queue and the output register, and one item is taken per cycle when the
// receiver keeps up. When m_tready is low the output register holds, the
// queue fills, and s_tready drops once both queue entries are occupied.
//
// Reset (synchronous, rst high) returns the sequencer to idle with all pins
// low, clears the read byte and empties the queue; no clearing pass is run.
// ----------------------------------------------------------------------------
module microwire_eeprom_master #(
  parameter int ADDR_BITS = mwe_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = mwe_pkg::DATA_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // address, write_value, miso, zero fill
  input  wire logic [((ADDR_BITS+DATA_BITS+1+7)/8)*8-1:0] s_tdata,
  // kind
  input  wire logic [mwe_pkg::KIND_W-1:0] s_tuser,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // chip_select, serial_clock, serial_out, read_value, read_done,
  // busy_res, rejected, zero fill
  output logic      [((6+DATA_BITS+7)/8)*8-1:0] m_tdata
);
  import mwe_pkg::*;

  localparam int IN_W    = ((ADDR_BITS + DATA_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_W   = ((6 + DATA_BITS + 7) / 8) * 8;
  localparam int ENTRY_W = 1 + KIND_W + ADDR_BITS + 3 + DATA_BITS + 1;

  // Positions of the result fields.
  localparam int O_CS   = 0;
  localparam int O_SCK  = 1;
  localparam int O_SO   = 2;
  localparam int O_DONE = 3 + DATA_BITS;
  localparam int O_BUSY = 4 + DATA_BITS;
  localparam int O_REJ  = 5 + DATA_BITS;

  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] q_data;
  logic               q_valid;
  logic               q_pop;

  // Decoder.
  mwe_front #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS),
    .IN_W      (IN_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .entry   (entry)
  );

  // Queue between decoder and sequencer.
  mwe_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_data (entry),
    .not_full  (s_tready),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  // Sequencer and output register.
  mwe_back #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS),
    .ENTRY_W   (ENTRY_W),
    .OUT_W     (OUT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Busy flag of the last delivered result item.
  logic last_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_busy <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      last_busy <= m_tdata[O_BUSY];
    end
  end

  // When no sequence runs, every bus pin rests low.
  a_idle_pins_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[O_BUSY] |-> !m_tdata[O_CS] && !m_tdata[O_SCK] && !m_tdata[O_SO])
    else $error("bus pins not low while idle");

  // A completed read ends the sequence on the same tick.
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[O_DONE] |-> !m_tdata[O_BUSY] && last_busy)
    else $error("read done outside a running sequence");

  // A command is rejected only while the previous tick left a sequence running.
  a_reject_when_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[O_REJ] |-> last_busy)
    else $error("command rejected while idle");

endmodule
`default_nettype wire

FILE: rtl/core/mwe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_front: input decoder
// Unpacks an input item, classifies its kind and builds the serial header,
// then packs everything the sequencer needs into one queue entry.
// ----------------------------------------------------------------------------
module mwe_front #(
  parameter int ADDR_BITS = mwe_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = mwe_pkg::DATA_BITS_DEF,
  parameter int IN_W      = 16,
  parameter int ENTRY_W   = 1 + mwe_pkg::KIND_W + ADDR_BITS + 3 + DATA_BITS + 1
) (
  input  wire logic [IN_W-1:0]            s_tdata,
  input  wire logic [mwe_pkg::KIND_W-1:0] s_tuser,
  output logic      [ENTRY_W-1:0]         entry
);
  import mwe_pkg::*;

  localparam int HDR_BITS = ADDR_BITS + 3;

  logic [KIND_W-1:0]    kind;
  logic [ADDR_BITS-1:0] address;
  logic [DATA_BITS-1:0] write_value;
  logic                 miso;
  logic                 is_cmd;
  logic [1:0]           opcode;
  logic [ADDR_BITS-1:0] low_bits;
  logic [HDR_BITS-1:0]  header;

  // Field unpacking, first field in the lowest bits; the kind rides in tuser.
  assign kind        = s_tuser;
  assign address     = s_tdata[ADDR_BITS-1:0];
  assign write_value = s_tdata[ADDR_BITS +: DATA_BITS];
  assign miso        = s_tdata[ADDR_BITS+DATA_BITS];

  // Opcode and address part of the header for each command.
  always_comb begin
    opcode   = OP_EXT;
    low_bits = '0;
    is_cmd   = 1'b1;
    case (cmd_t'(kind))
      CMD_READ: begin
        opcode   = OP_READ;
        low_bits = address;
      end
      CMD_WRITE: begin
        opcode   = OP_WRITE;
        low_bits = address;
      end
      CMD_EWEN: low_bits = {EXT_EWEN, {(ADDR_BITS-2){1'b0}}};
      CMD_EWDS: low_bits = {EXT_EWDS, {(ADDR_BITS-2){1'b0}}};
      CMD_ERAL: low_bits = {EXT_ERAL, {(ADDR_BITS-2){1'b0}}};
      CMD_WRAL: low_bits = {EXT_WRAL, {(ADDR_BITS-2){1'b0}}};
      default:  is_cmd   = 1'b0;
    endcase
  end

  assign header = {1'b1, opcode, low_bits};

  // Entry layout from the lowest bit: is_cmd, kind, header, data, miso.
  assign entry = {miso, write_value, header, kind, is_cmd};

endmodule
`default_nettype wire

FILE: rtl/core/mwe_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_queue: short item queue
// A small register FIFO between the decoder and the sequencer so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module mwe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mwe_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  not_full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  not_empty
);
  import mwe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mwe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_back: bus sequencer
// Runs one tick of the Microwire sequence for each queued item and holds the
// result item in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module mwe_back #(
  parameter int ADDR_BITS = mwe_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = mwe_pkg::DATA_BITS_DEF,
  parameter int ENTRY_W   = 1 + mwe_pkg::KIND_W + ADDR_BITS + 3 + DATA_BITS + 1,
  parameter int OUT_W     = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire logic [ENTRY_W-1:0] q_data,
  output logic                    q_pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic      [OUT_W-1:0]   m_tdata
);
  import mwe_pkg::*;

  localparam int HDR_BITS = ADDR_BITS + 3;
  localparam int MAX_BITS = (HDR_BITS > DATA_BITS) ? HDR_BITS : DATA_BITS;
  localparam int CNT_W    = $clog2(MAX_BITS + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR_LO, PH_HDR_HI, PH_DAT_LO, PH_DAT_HI,
    PH_RD_LO, PH_RD_HI, PH_DESEL, PH_POLL, PH_END
  } phase_t;

  // Queue entry fields.
  logic                 e_is_cmd;
  logic [KIND_W-1:0]    e_kind;
  logic [HDR_BITS-1:0]  e_header;
  logic [DATA_BITS-1:0] e_wval;
  logic                 e_miso;

  assign {e_miso, e_wval, e_header, e_kind, e_is_cmd} = q_data;

  // Sequencer state.
  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     bit_count, bit_count_next, cnt_inc;
  logic [HDR_BITS-1:0]  header_shift, header_shift_next;
  logic [DATA_BITS-1:0] data_shift, data_shift_next;
  logic [DATA_BITS-1:0] read_assembly, read_assembly_next;
  logic [KIND_W-1:0]    current_command, current_command_next;
  logic                 cs, cs_next, sck, sck_next, so, so_next;
  logic                 done, rej;

  assign q_pop   = q_valid && (!m_tvalid || m_tready);
  assign cnt_inc = bit_count + 1'b1;

  // One bus tick.
  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    header_shift_next    = header_shift;
    data_shift_next      = data_shift;
    read_assembly_next   = read_assembly;
    current_command_next = current_command;
    cs_next              = cs;
    sck_next             = sck;
    so_next              = so;
    done                 = 1'b0;
    rej                  = e_is_cmd && (phase != PH_IDLE);

    if (e_is_cmd && (phase == PH_IDLE)) begin
      // A new command raises select and drives the start bit at once.
      current_command_next = e_kind;
      header_shift_next    = e_header;
      data_shift_next      = e_wval;
      bit_count_next       = '0;
      cs_next              = 1'b1;
      sck_next             = 1'b0;
      so_next              = e_header[HDR_BITS-1];
      phase_next           = PH_HDR_HI;
    end else begin
      case (phase)
        PH_HDR_LO: begin
          cs_next    = 1'b1;
          sck_next   = 1'b0;
          so_next    = header_shift[HDR_BITS-1];
          phase_next = PH_HDR_HI;
        end
        PH_HDR_HI: begin
          sck_next          = 1'b1;
          header_shift_next = {header_shift[HDR_BITS-2:0], 1'b0};
          if (cnt_inc >= CNT_W'(HDR_BITS)) begin
            bit_count_next = '0;
            if (current_command == CMD_READ) begin
              data_shift_next = '0;
              phase_next      = PH_RD_LO;
            end else if (current_command == CMD_WRITE || current_command == CMD_WRAL) begin
              phase_next = PH_DAT_LO;
            end else begin
              phase_next = PH_END;
            end
          end else begin
            bit_count_next = cnt_inc;
            phase_next     = PH_HDR_LO;
          end
        end
        PH_DAT_LO: begin
          sck_next   = 1'b0;
          so_next    = data_shift[DATA_BITS-1];
          phase_next = PH_DAT_HI;
        end
        PH_DAT_HI: begin
          sck_next        = 1'b1;
          data_shift_next = {data_shift[DATA_BITS-2:0], 1'b0};
          if (cnt_inc >= CNT_W'(DATA_BITS)) begin
            bit_count_next = '0;
            phase_next     = PH_DESEL;
          end else begin
            bit_count_next = cnt_inc;
            phase_next     = PH_DAT_LO;
          end
        end
        PH_RD_LO: begin
          sck_next   = 1'b0;
          so_next    = 1'b0;
          phase_next = PH_RD_HI;
        end
        PH_RD_HI: begin
          // Sample the EEPROM output after the rising serial clock.
          sck_next        = 1'b1;
          data_shift_next = {data_shift[DATA_BITS-2:0], e_miso};
          if (cnt_inc >= CNT_W'(DATA_BITS)) begin
            bit_count_next = '0;
            phase_next     = PH_END;
          end else begin
            bit_count_next = cnt_inc;
            phase_next     = PH_RD_LO;
          end
        end
        PH_DESEL: begin
          cs_next    = 1'b0;
          sck_next   = 1'b0;
          so_next    = 1'b0;
          phase_next = PH_POLL;
        end
        PH_POLL: begin
          // Ready poll: select is raised first, then busy ends on a high MISO.
          if (cs && e_miso) begin
            cs_next    = 1'b0;
            phase_next = PH_IDLE;
          end else begin
            cs_next = 1'b1;
          end
        end
        PH_END: begin
          cs_next    = 1'b0;
          sck_next   = 1'b0;
          so_next    = 1'b0;
          phase_next = PH_IDLE;
          if (current_command == CMD_READ) begin
            read_assembly_next = data_shift;
            done               = 1'b1;
          end
        end
        default: begin
          cs_next    = 1'b0;
          sck_next   = 1'b0;
          so_next    = 1'b0;
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // State and output register, advanced once per consumed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= '0;
      header_shift    <= '0;
      data_shift      <= '0;
      read_assembly   <= '0;
      current_command <= '0;
      cs              <= 1'b0;
      sck             <= 1'b0;
      so              <= 1'b0;
      m_tvalid        <= 1'b0;
      m_tdata         <= '0;
    end else begin
      if (q_pop) begin
        phase           <= phase_next;
        bit_count       <= bit_count_next;
        header_shift    <= header_shift_next;
        data_shift      <= data_shift_next;
        read_assembly   <= read_assembly_next;
        current_command <= current_command_next;
        cs              <= cs_next;
        sck             <= sck_next;
        so              <= so_next;
        m_tdata         <= OUT_W'({rej, (phase_next != PH_IDLE), done,
                                   read_assembly_next, so_next, sck_next, cs_next});
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Microwire EEPROM master
// Every input item is one bus tick, and each one gives one result item. The
// bench plans tick streams ahead of time: whole command sequences, with stray
// commands and noise mixed in. It predicts the pin levels and flags of every
// accepted tick and compares each result item field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import mwe_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  // Sequencer phases of the bus master.
  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR_LO, PH_HDR_HI, PH_DAT_LO, PH_DAT_HI,
    PH_RD_LO, PH_RD_HI, PH_DESEL, PH_POLL, PH_END
  } bus_phase_t;

  typedef struct packed {
    bus_phase_t phase;
    logic [3:0] nbits;
    logic [9:0] hdr;
    logic [7:0] shreg;
    logic [7:0] last_byte;
    cmd_t       cmd;
    logic       cs;
    logic       sck;
    logic       so;
  } bus_state_t;

  typedef struct packed {
    cmd_t       kind;
    logic [6:0] addr;
    logic [7:0] wval;
    logic       miso;
    logic       drain;
  } tick_item_t;

  typedef struct packed {
    logic       cs;
    logic       sck;
    logic       so;
    logic [7:0] rd_byte;
    logic       rd_done;
    logic       busy;
    logic       rejected;
  } pin_levels_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  tick_item_t  tick_items_q[$];
  pin_levels_t pin_levels_q[$];
  bus_state_t  plan_st;
  bus_state_t  track_st;
  int          errors = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          send_wait = 0;
  int          recv_stall = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  int          idle_cycles = 0;

  microwire_eeprom_master u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Advance the bus state by one tick and return the pins and flags after it.
  function automatic pin_levels_t bus_tick(inout bus_state_t s, input tick_item_t t);
    pin_levels_t r;
    logic        rej;
    logic        done;
    rej  = 1'b0;
    done = 1'b0;
    if (t.kind != CMD_TICK && t.kind != CMD_NONE) begin
      if (s.phase == PH_IDLE) begin
        s.cmd   = t.kind;
        s.shreg = t.wval;
        s.nbits = 4'd0;
        s.phase = PH_HDR_LO;
        case (t.kind)
          CMD_READ:  s.hdr = {1'b1, OP_READ, t.addr};
          CMD_WRITE: s.hdr = {1'b1, OP_WRITE, t.addr};
          CMD_EWEN:  s.hdr = {1'b1, OP_EXT, EXT_EWEN, 5'b0};
          CMD_EWDS:  s.hdr = {1'b1, OP_EXT, EXT_EWDS, 5'b0};
          CMD_ERAL:  s.hdr = {1'b1, OP_EXT, EXT_ERAL, 5'b0};
          default:   s.hdr = {1'b1, OP_EXT, EXT_WRAL, 5'b0};
        endcase
      end else begin
        rej = 1'b1;
      end
    end
    case (s.phase)
      PH_HDR_LO: begin
        s.cs    = 1'b1;
        s.sck   = 1'b0;
        s.so    = s.hdr[9];
        s.phase = PH_HDR_HI;
      end
      PH_HDR_HI: begin
        s.sck   = 1'b1;
        s.hdr   = {s.hdr[8:0], 1'b0};
        s.nbits = s.nbits + 4'd1;
        if (s.nbits >= 4'd10) begin
          s.nbits = 4'd0;
          if (s.cmd == CMD_READ) begin
            s.shreg = 8'd0;
            s.phase = PH_RD_LO;
          end else if (s.cmd == CMD_WRITE || s.cmd == CMD_WRAL) begin
            s.phase = PH_DAT_LO;
          end else begin
            s.phase = PH_END;
          end
        end else begin
          s.phase = PH_HDR_LO;
        end
      end
      PH_DAT_LO: begin
        s.sck   = 1'b0;
        s.so    = s.shreg[7];
        s.phase = PH_DAT_HI;
      end
      PH_DAT_HI: begin
        s.sck   = 1'b1;
        s.shreg = {s.shreg[6:0], 1'b0};
        s.nbits = s.nbits + 4'd1;
        if (s.nbits >= 4'd8) begin
          s.nbits = 4'd0;
          s.phase = PH_DESEL;
        end else begin
          s.phase = PH_DAT_LO;
        end
      end
      PH_RD_LO: begin
        s.sck   = 1'b0;
        s.so    = 1'b0;
        s.phase = PH_RD_HI;
      end
      PH_RD_HI: begin
        s.sck   = 1'b1;
        s.shreg = {s.shreg[6:0], t.miso};
        s.nbits = s.nbits + 4'd1;
        if (s.nbits >= 4'd8) begin
          s.nbits = 4'd0;
          s.phase = PH_END;
        end else begin
          s.phase = PH_RD_LO;
        end
      end
      PH_DESEL: begin
        s.cs    = 1'b0;
        s.sck   = 1'b0;
        s.so    = 1'b0;
        s.phase = PH_POLL;
      end
      PH_POLL: begin
        // The first poll tick only reselects; later a high miso ends it.
        if (s.cs && t.miso) begin
          s.cs    = 1'b0;
          s.phase = PH_IDLE;
        end else begin
          s.cs = 1'b1;
        end
      end
      PH_END: begin
        s.cs  = 1'b0;
        s.sck = 1'b0;
        s.so  = 1'b0;
        if (s.cmd == CMD_READ) begin
          s.last_byte = s.shreg;
          done = 1'b1;
        end
        s.phase = PH_IDLE;
      end
      default: begin
        s.cs    = 1'b0;
        s.sck   = 1'b0;
        s.so    = 1'b0;
        s.phase = PH_IDLE;
      end
    endcase
    r.cs       = s.cs;
    r.sck      = s.sck;
    r.so       = s.so;
    r.rd_byte  = s.last_byte;
    r.rd_done  = done;
    r.busy     = (s.phase != PH_IDLE);
    r.rejected = rej;
    return r;
  endfunction

  // Queue one tick and keep the planning copy of the bus state in step.
  task automatic push_tick(input cmd_t kind, input logic [6:0] addr, input logic [7:0] wval,
                           input logic miso, input logic drain);
    tick_item_t  t;
    t.kind  = kind;
    t.addr  = addr;
    t.wval  = wval;
    t.miso  = miso;
    t.drain = drain;
    void'(bus_tick(plan_st, t));
    tick_items_q.push_back(t);
  endtask

  // Queue a command and enough ticks to carry it to the end. Stray commands
  // land in the middle at noise_pct percent; poll ticks see miso high at
  // ready_pct percent.
  task automatic run_command(input cmd_t kind, input logic [6:0] addr, input logic [7:0] wval,
                             input int noise_pct, input int ready_pct, input logic drain);
    cmd_t k;
    logic m;
    push_tick(kind, addr, wval, 1'($urandom_range(0, 1)), drain);
    while (plan_st.phase != PH_IDLE) begin
      k = CMD_TICK;
      if ($urandom_range(0, 99) < noise_pct) k = cmd_t'($urandom_range(1, 7));
      if (plan_st.phase == PH_POLL) m = ($urandom_range(0, 99) < ready_pct);
      else m = 1'($urandom_range(0, 1));
      push_tick(k, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), m, 1'b0);
    end
  endtask

  // Sender: offers queued ticks with random gaps and drain pauses.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pin_levels_q.push_back(bus_tick(track_st, tick_items_q[0]));
        void'(tick_items_q.pop_front());
        n_sent++;
        if (n_sent % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
        send_wait = send_burst ? 0 : $urandom_range(0, 6);
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_tvalid <= 1'b0;
        end else if (tick_items_q.size() != 0 &&
                     !(tick_items_q[0].drain && pin_levels_q.size() != 0)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {tick_items_q[0].miso, tick_items_q[0].wval, tick_items_q[0].addr};
          s_tuser  <= tick_items_q[0].kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // Receiver: random stalls, one long hold, and a field-by-field compare.
  always @(posedge clk) begin
    pin_levels_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pin_levels_q.size() == 0) begin
          $error("result item %h arrived with nothing expected", m_tdata);
          errors++;
        end else begin
          want = pin_levels_q.pop_front();
          cmp_field("chip_select", want.cs, m_tdata[0]);
          cmp_field("serial_clock", want.sck, m_tdata[1]);
          cmp_field("serial_out", want.so, m_tdata[2]);
          cmp_field("read_value", want.rd_byte, m_tdata[10:3]);
          cmp_field("read_done", want.rd_done, m_tdata[11]);
          cmp_field("busy_res", want.busy, m_tdata[12]);
          cmp_field("rejected", want.rejected, m_tdata[13]);
        end
        n_got++;
        if (n_got % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
        recv_stall = recv_burst ? 0 : $urandom_range(0, 6);
        // One long hold so that the block backs up and stalls its input.
        if (n_got == 150) recv_stall = 80;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int   n_cmd;
    int   ready_pct;
    cmd_t k;
    logic [6:0] a;
    plan_st  = '0;
    track_st = '0;

    // Directed part: idle ticks, every command, address and data extremes.
    push_tick(CMD_TICK, 7'd0, 8'd0, 1'b0, 1'b0);
    push_tick(CMD_NONE, 7'd127, 8'd255, 1'b1, 1'b0);
    run_command(CMD_READ, 7'd0, 8'd0, 0, 50, 1'b0);
    run_command(CMD_READ, 7'd127, 8'd255, 0, 50, 1'b0);
    run_command(CMD_EWEN, 7'd127, 8'd0, 0, 50, 1'b0);
    run_command(CMD_WRITE, 7'd127, 8'hFF, 0, 50, 1'b0);
    run_command(CMD_WRITE, 7'd0, 8'h00, 0, 10, 1'b0);
    run_command(CMD_ERAL, 7'd0, 8'hFF, 0, 50, 1'b0);
    run_command(CMD_WRAL, 7'd85, 8'hA5, 0, 100, 1'b0);
    run_command(CMD_WRAL, 7'd42, 8'h5A, 0, 30, 1'b0);
    run_command(CMD_EWDS, 7'd127, 8'hFF, 0, 50, 1'b0);
    // Commands that arrive while a sequence runs are turned away.
    run_command(CMD_READ, 7'd85, 8'h00, 50, 50, 1'b0);
    run_command(CMD_WRITE, 7'd42, 8'hC3, 40, 40, 1'b0);

    // Random part: mostly whole sequences with random content, some noise.
    n_cmd = 0;
    while (tick_items_q.size() < 600) begin
      if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 1) ? CMD_NONE : CMD_TICK;
      else k = cmd_t'($urandom_range(1, 6));
      a = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 7) == 0) a = $urandom_range(0, 1) ? 7'd127 : 7'd0;
      case ($urandom_range(0, 2))
        0:       ready_pct = 5;
        1:       ready_pct = 30;
        default: ready_pct = 80;
      endcase
      // Every twelfth command waits until all earlier results are in.
      run_command(k, a, 8'($urandom_range(0, 255)), $urandom_range(0, 10), ready_pct,
                  (n_cmd % 12 == 0));
      n_cmd++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (tick_items_q.size() != 0) @(posedge clk);
    while (pin_levels_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pin_levels_q.size() != 0) begin
      $error("%0d expected result items never arrived", pin_levels_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
